// File: hw/rtl/glf_pkg.sv
// ----------------------------------------------------------------------------
// glf_pkg
// Types, codes and helper functions shared by the light level field block.
// ----------------------------------------------------------------------------
package glf_pkg;

  // grid edge length; coordinates at or above it are pulled to the last cell
  localparam int unsigned GridSize = 16;

  localparam int unsigned CoordW    = 4;
  localparam int unsigned StrengthW = 4;
  localparam int unsigned LevelW    = 4;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  // one classified beat travelling from the front to the back
  typedef struct packed {
    cmd_e                 cmd;
    logic [CoordW-1:0]    x;
    logic [CoordW-1:0]    y;
    logic [StrengthW-1:0] strength;
  } item_t;

  // one stored light source
  typedef struct packed {
    logic [CoordW-1:0]    x;
    logic [CoordW-1:0]    y;
    logic [StrengthW-1:0] strength;
  } src_t;

  // one result beat
  typedef struct packed {
    logic [LevelW-1:0] level;
    status_e           status;
  } res_t;

  // pull a coordinate into the grid
  function automatic logic [CoordW-1:0] clamp_coord(logic [CoordW-1:0] c);
    logic [CoordW-1:0] r;
    r = c;
    if (int'(c) >= int'(GridSize)) begin
      r = CoordW'(GridSize - 1);
    end
    return r;
  endfunction

  // strength minus chebyshev distance, floored at zero
  function automatic logic [LevelW-1:0] light_contrib(src_t src, logic [CoordW-1:0] qx,
                                                      logic [CoordW-1:0] qy);
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [CoordW-1:0] d;
    dx = (src.x > qx) ? (src.x - qx) : (qx - src.x);
    dy = (src.y > qy) ? (src.y - qy) : (qy - src.y);
    d  = (dx > dy) ? dx : dy;
    return (src.strength > d) ? LevelW'(src.strength - d) : '0;
  endfunction

endpackage

// File: hw/rtl/glf_fifo.sv
// ----------------------------------------------------------------------------
// glf_fifo
// Two-entry queue used between the front and the back and on the result side.
// ----------------------------------------------------------------------------
module glf_fifo #(
  parameter int unsigned DataW = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);

  logic [DataW-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/glf_front.sv
// ----------------------------------------------------------------------------
// glf_front
// Accepts input beats, clamps coordinates to the grid and queues the items.
// ----------------------------------------------------------------------------
module glf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic                            command_i,
  input  logic [glf_pkg::CoordW-1:0]      pos_x_i,
  input  logic [glf_pkg::CoordW-1:0]      pos_y_i,
  input  logic [glf_pkg::StrengthW-1:0]   strength_i,
  output logic                            item_vld_o,
  output glf_pkg::item_t                  item_o,
  input  logic                            item_pop_i
);

  glf_pkg::item_t item_in;
  logic           item_empty;

  // classify and clamp the incoming beat
  always_comb begin
    item_in.cmd      = glf_pkg::cmd_e'(command_i);
    item_in.x        = glf_pkg::clamp_coord(pos_x_i);
    item_in.y        = glf_pkg::clamp_coord(pos_y_i);
    item_in.strength = strength_i;
  end

  glf_fifo #(
    .DataW($bits(glf_pkg::item_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (item_pop_i),
    .data_o (item_o),
    .empty_o(item_empty)
  );

  assign item_vld_o = !item_empty;

endmodule

// File: hw/rtl/glf_back.sv
// ----------------------------------------------------------------------------
// glf_back
// Source store and scan engine; adds write one entry unless the store is full, queries sweep the store.
// ----------------------------------------------------------------------------
module glf_back #(
  parameter int unsigned MaxSources = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_vld_i,
  input  glf_pkg::item_t                item_i,
  output logic                          item_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [glf_pkg::LevelW-1:0]    level_o,
  output logic                          status_o
);

  localparam int unsigned CntW = $clog2(MaxSources + 1);
  localparam int unsigned IdxW = (MaxSources > 1) ? $clog2(MaxSources) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [glf_pkg::CoordW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [glf_pkg::LevelW-1:0] best_q, best_d;
  logic                       rd_vld_q;
  glf_pkg::src_t              rdata_q;
  glf_pkg::src_t              store [MaxSources];

  logic                       store_full;
  logic                       idx_last;
  logic                       wr_en;
  glf_pkg::src_t              wr_src;
  logic [glf_pkg::LevelW-1:0] contrib;
  logic [glf_pkg::LevelW-1:0] best_new;
  logic                       res_push;
  logic                       res_full;
  glf_pkg::res_t              res_in;
  glf_pkg::res_t              res_out;

  assign store_full = (count_q == CntW'(MaxSources));
  assign idx_last   = (CntW'(idx_q) == (count_q - CntW'(1)));
  assign contrib    = glf_pkg::light_contrib(rdata_q, qx_q, qy_q);
  assign best_new   = (contrib > best_q) ? contrib : best_q;
  assign item_pop_o = (state_q == StIdle) && item_vld_i && !res_full;

  assign wr_src.x        = item_i.x;
  assign wr_src.y        = item_i.y;
  assign wr_src.strength = item_i.strength;

  // sequencer for adds and query sweeps
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    qx_d     = qx_q;
    qy_d     = qy_q;
    best_d   = best_q;
    wr_en    = 1'b0;
    res_push = 1'b0;
    res_in.level  = '0;
    res_in.status = glf_pkg::STATUS_OK;
    case (state_q)
      StIdle: begin
        if (item_pop_o) begin
          if (item_i.cmd == glf_pkg::CMD_ADD) begin
            res_push = 1'b1;
            if (store_full) begin
              res_in.status = glf_pkg::STATUS_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            res_push = 1'b1;
          end else begin
            qx_d    = item_i.x;
            qy_d    = item_i.y;
            idx_d   = '0;
            best_d  = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rd_vld_q) begin
          best_d = best_new;
        end
        idx_d = idx_q + IdxW'(1);
        if (idx_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        res_push     = 1'b1;
        res_in.level = best_new;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= (state_q == StScan);
    end
  end

  // query coordinates and running maximum
  always_ff @(posedge clk_i) begin
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    best_q <= best_d;
  end

  // source memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[count_q[IdxW-1:0]] <= wr_src;
    end
    if (state_q == StScan) begin
      rdata_q <= store[idx_q];
    end
  end

  glf_fifo #(
    .DataW($bits(glf_pkg::res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .data_o (res_out),
    .empty_o(empty_o)
  );

  assign level_o  = res_out.level;
  assign status_o = res_out.status;

endmodule

// File: hw/rtl/grid_light_level_field.sv
// ----------------------------------------------------------------------------
// grid_light_level_field
// Light level of a grid cell from a store of point sources.
// ----------------------------------------------------------------------------
// Each beat in gives one result beat out, in order. An add stores a source
// (refused with status 1 once MAX_SOURCES are held); a query returns the
// highest of strength minus Chebyshev distance over the stored sources,
// floored at zero. Items are queued two deep behind push/full, results two
// deep behind empty/pop. In the execution stage an add is done in the idle state
// and a query sweeps the N stored sources in the scan state, then answers from
// the drain state; the source memory read port gives the scan one source per cycle.
module grid_light_level_field #(
  parameter int unsigned MAX_SOURCES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           command_i,
  input  logic [glf_pkg::CoordW-1:0]     pos_x_i,
  input  logic [glf_pkg::CoordW-1:0]     pos_y_i,
  input  logic [glf_pkg::StrengthW-1:0]  strength_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [glf_pkg::LevelW-1:0]     level_o,
  output logic                           status_o
);

  logic           item_vld;
  logic           item_pop;
  glf_pkg::item_t item;

  // front: accept and classify
  glf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .command_i  (command_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .strength_i (strength_i),
    .item_vld_o (item_vld),
    .item_o     (item),
    .item_pop_i (item_pop)
  );

  // back: store and scan
  glf_back #(
    .MaxSources(MAX_SOURCES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .item_pop_o (item_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .level_o    (level_o),
    .status_o   (status_o)
  );

`ifndef SYNTHESIS
  // a refused add never carries a level
  a_full_no_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == glf_pkg::STATUS_FULL) |-> (level_o == '0))
    else $error("refused add carries a nonzero level");

  // the back only takes an item that is there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_vld)
    else $error("item taken from an empty command queue");

  // an accepted beat into an empty command queue is registered and then shows as valid
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !item_vld) |=> item_vld)
    else $error("accepted beat did not reach the command queue");
`endif

endmodule
